/* hdl/amd_pkg.sv */
// Shared types, address map table and target codes for the address map decoder.
package amd_pkg;

    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned OFFSET_W   = 26;
    localparam int unsigned MAP_N      = 12;
    localparam int unsigned BOOT_OFF_W = 12;

    localparam logic [OFFSET_W-1:0] SRAM_HALF    = 26'h001_0000;
    localparam logic [15:0]         OVERLAY_PAGE = 16'hFFFF;

    // configuration register indexes
    localparam logic CFG_BOOT_ROM_OVERLAY = 1'b0;
    localparam logic CFG_SRAM_SWAP        = 1'b1;

    typedef enum logic [2:0] {
        TGT_MEM1 = 3'd0,
        TGT_MEM2 = 3'd1,
        TGT_SRAM = 3'd2,
        TGT_BOOT = 3'd3,
        TGT_REGS = 3'd4,
        TGT_NONE = 3'd5
    } target_t;

    typedef enum logic [2:0] {
        KIND_M1 = 3'd0,
        KIND_M2 = 3'd1,
        KIND_SA = 3'd2,
        KIND_SB = 3'd3,
        KIND_RG = 3'd4
    } kind_t;

    typedef struct packed {
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        kind_t             kind;
    } map_range_t;

    // scanned in order; a later hit overrides an earlier one
    localparam map_range_t ADDR_MAP [MAP_N] = '{
        '{32'h8000_0000, 32'h817F_FFFF, KIND_M1},
        '{32'hC000_0000, 32'hC17F_FFFF, KIND_M1},
        '{32'hD000_0000, 32'hD3FF_FFFF, KIND_M2},
        '{32'hD000_0000, 32'hD3FF_FFFF, KIND_M2},
        '{32'hFFFE_0000, 32'hFFFE_FFFF, KIND_SA},
        '{32'hFFFF_0000, 32'hFFFF_FFFF, KIND_SB},
        '{32'hFFF0_0000, 32'hFFF0_FFFF, KIND_SA},
        '{32'hFFF1_0000, 32'hFFF1_FFFF, KIND_SB},
        '{32'h0D40_0000, 32'h0D40_FFFF, KIND_SA},
        '{32'h0D41_0000, 32'h0D41_FFFF, KIND_SB},
        '{32'h0D00_0000, 32'h0D00_FFFF, KIND_RG},
        '{32'h0D80_0000, 32'h0D80_FFFF, KIND_RG}
    };

    // stage 1 -> stage 2
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [MAP_N-1:0]  hits;
    } match_t;

    // stage 2 -> stage 3
    typedef struct packed {
        logic                  hit;
        kind_t                 kind;
        logic [OFFSET_W-1:0]   rel;
        logic                  in_overlay;
        logic [BOOT_OFF_W-1:0] boot_off;
    } select_t;

endpackage

/* hdl/amd_match.sv */
// Stage 1: compares the address against every range of the map.
module amd_match (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [31:0]     address,
    output logic            m_valid,
    input  logic            m_stall,
    output amd_pkg::match_t m_data
);
    import amd_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    match_t           data_reg;
    logic [MAP_N-1:0] hits;

    always_comb
    begin
        for (int i = 0; i < MAP_N; i++)
        begin
            hits[i] = (address >= ADDR_MAP[i].lo) && (address <= ADDR_MAP[i].hi);
        end
    end

    assign in_stall   = valid_reg & m_stall;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            data_reg.addr <= address;
            data_reg.hits <= hits;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

/* hdl/amd_select.sv */
// Stage 2: picks the last matching range and forms the range-relative offset.
module amd_select (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             m_valid,
    output logic             m_stall,
    input  amd_pkg::match_t  m_data,
    output logic             s_valid,
    input  logic             s_stall,
    output amd_pkg::select_t s_data
);
    import amd_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    select_t     data_reg;
    select_t     data_next;
    logic [31:0] lo;
    logic [31:0] rel_full;

    always_comb
    begin
        data_next.hit  = 1'b0;
        data_next.kind = KIND_M1;
        lo             = '0;
        for (int i = 0; i < MAP_N; i++)
        begin
            if (m_data.hits[i])
            begin
                data_next.hit  = 1'b1;
                data_next.kind = ADDR_MAP[i].kind;
                lo             = ADDR_MAP[i].lo;
            end
        end
        rel_full             = m_data.addr - lo;
        data_next.rel        = rel_full[OFFSET_W-1:0];
        data_next.in_overlay = (m_data.addr[31:16] == OVERLAY_PAGE);
        data_next.boot_off   = m_data.addr[BOOT_OFF_W-1:0];
    end

    assign m_stall    = valid_reg & s_stall;
    assign valid_next = m_stall ? valid_reg : m_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_valid && !m_stall)
        begin
            data_reg <= data_next;
        end
    end

    assign s_valid = valid_reg;
    assign s_data  = data_reg;

endmodule

/* hdl/amd_resolve.sv */
// Stage 3: applies swap and overlay, forms target and offset; holds the output register.
module amd_resolve (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_valid,
    output logic                    s_stall,
    input  amd_pkg::select_t        s_data,
    input  logic                    boot_rom_overlay,
    input  logic                    sram_swap,
    output logic                    out_valid,
    input  logic                    out_stall,
    output amd_pkg::target_t        target,
    output logic [amd_pkg::OFFSET_W-1:0] offset
);
    import amd_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    target_t             target_reg;
    target_t             target_next;
    logic [OFFSET_W-1:0] offset_reg;
    logic [OFFSET_W-1:0] offset_next;
    logic                is_a;

    always_comb
    begin
        is_a        = (s_data.kind == KIND_SA);
        target_next = TGT_NONE;
        offset_next = '0;
        if (s_data.hit)
        begin
            case (s_data.kind)
                KIND_M1:
                begin
                    target_next = TGT_MEM1;
                    offset_next = s_data.rel;
                end
                KIND_M2:
                begin
                    target_next = TGT_MEM2;
                    offset_next = s_data.rel;
                end
                KIND_SA, KIND_SB:
                begin
                    if (sram_swap)
                    begin
                        target_next = TGT_SRAM;
                        offset_next = is_a ? (SRAM_HALF + s_data.rel) : s_data.rel;
                    end
                    else if (!is_a && boot_rom_overlay && s_data.in_overlay)
                    begin
                        target_next = TGT_BOOT;
                        offset_next = {{(OFFSET_W-BOOT_OFF_W){1'b0}}, s_data.boot_off};
                    end
                    else
                    begin
                        target_next = TGT_SRAM;
                        offset_next = is_a ? s_data.rel : (SRAM_HALF + s_data.rel);
                    end
                end
                KIND_RG:
                begin
                    target_next = TGT_REGS;
                    offset_next = {2'b00, s_data.rel[OFFSET_W-1:2]};
                end
                default:
                begin
                    target_next = TGT_NONE;
                    offset_next = '0;
                end
            endcase
        end
    end

    assign s_stall    = valid_reg & out_stall;
    assign valid_next = s_stall ? valid_reg : s_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && !s_stall)
        begin
            target_reg <= target_next;
            offset_reg <= offset_next;
        end
    end

    assign out_valid = valid_reg;
    assign target    = target_reg;
    assign offset    = offset_reg;

endmodule

/* hdl/address_map_decoder.sv */
// Top level of the address map decoder: three-stage pipeline plus config registers.
//
// Usage notes
// - Input channel: address with in_valid/in_stall. An item is taken at a
//   rising edge where in_valid is high and in_stall is low.
// - Output channel: target/offset with out_valid/out_stall, same rules.
// - Config port: cfg_write/cfg_index/cfg_data. Index 0 is the boot ROM
//   overlay flag, index 1 the SRAM swap flag. Write only while idle.
// - Pipeline: an accepted item passes the stage 1, 2 and 3 registers on
//   its way to out_valid. Stage 1 does the twelve range compares, stage 2
//   the last-hit select and the subtract of the range base, stage 3 the
//   swap/overlay resolve into the output register.
// - Throughput: one item per cycle while out_stall stays low.
// - Stall: each stage holds while it is full and the stage after it stalls.
//   Empty stages keep filling, so up to three items sit in the pipe while
//   a result waits; in_stall rises only when all stages are full.
// - Reset: pipeline empties, overlay flag set, swap flag clear.
// - Unmapped addresses return target 5 with offset 0.
module address_map_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  target,
    output logic [amd_pkg::OFFSET_W-1:0] offset
);
    import amd_pkg::*;

    logic    overlay_reg;
    logic    overlay_next;
    logic    swap_reg;
    logic    swap_next;

    logic    m_valid;
    logic    m_stall;
    match_t  m_data;
    logic    s_valid;
    logic    s_stall;
    select_t s_data;
    target_t target_w;

    // config registers; each write stores the one-bit cfg_data into the flag chosen by cfg_index
    always_comb
    begin
        overlay_next = overlay_reg;
        swap_next    = swap_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_BOOT_ROM_OVERLAY: overlay_next = cfg_data;
                CFG_SRAM_SWAP:        swap_next    = cfg_data;
                default:
                begin
                    overlay_next = overlay_reg;
                    swap_next    = swap_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlay_reg <= 1'b1;
            swap_reg    <= 1'b0;
        end
        else
        begin
            overlay_reg <= overlay_next;
            swap_reg    <= swap_next;
        end
    end

    // stage 1: range compares
    amd_match u_match (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .address  (address),
        .m_valid  (m_valid),
        .m_stall  (m_stall),
        .m_data   (m_data)
    );

    // stage 2: last-hit select, base subtract
    amd_select u_select (
        .clk     (clk),
        .rst_n   (rst_n),
        .m_valid (m_valid),
        .m_stall (m_stall),
        .m_data  (m_data),
        .s_valid (s_valid),
        .s_stall (s_stall),
        .s_data  (s_data)
    );

    // stage 3: swap/overlay resolve, output register
    amd_resolve u_resolve (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_valid          (s_valid),
        .s_stall          (s_stall),
        .s_data           (s_data),
        .boot_rom_overlay (overlay_reg),
        .sram_swap        (swap_reg),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .target           (target_w),
        .offset           (offset)
    );

    assign target = target_w;

endmodule

/* hdl/amd_checker.sv */
// Port-level checks for the address map decoder, bound to the top level.
module amd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  target,
    input logic [amd_pkg::OFFSET_W-1:0] offset
);
    import amd_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(target) && $stable(offset))
        else $error("stalled result changed");

    // unmapped addresses carry a zero offset
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (target == TGT_NONE) |-> (offset == '0))
        else $error("unmapped result with nonzero offset");

    // boot ROM offsets fit 12 bits, SRAM offsets fit 17 bits
    a_small_offsets: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((target == TGT_BOOT && offset[OFFSET_W-1:12] != '0) ||
                      (target == TGT_SRAM && offset[OFFSET_W-1:17] != '0)) |-> 1'b0)
        else $error("boot or sram offset out of range");

    // with the output side free, an accepted item shows up at the output
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
        else $error("item did not reach the output in three cycles");

endmodule

bind address_map_decoder amd_checker u_amd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .target    (target),
    .offset    (offset)
);
